>>> sv/spa_pkg.sv
// Shared constants and helper functions for the single-precision sine pipeline.
package spa_pkg;

  localparam int WORD_W = 32;

  // binary32 constants
  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] POS_ZERO  = 32'h0000_0000;
  localparam logic [31:0] NEG_ZERO  = 32'h8000_0000;
  localparam logic [31:0] PI_HI     = 32'h4049_0FDB;
  localparam logic [31:0] NEG_PI_HI = 32'hC049_0FDB;
  localparam logic [31:0] PI_LO     = 32'hB3BB_BD2E;
  localparam logic [31:0] NEG_PI_LO = 32'h33BB_BD2E;
  localparam logic [31:0] PERIOD    = 32'h40C9_0FDB;  // 2 * PI_HI, exact

  // unit latencies
  localparam int LAT_ADD       = 3;
  localparam int LAT_MUL       = 3;
  localparam int REM_STEPS     = 8;    // shift-subtract steps per remainder stage
  localparam int REM_MAX_SHIFT = 125;  // largest finite exponent minus the period's
  localparam int REM_STAGES    = (REM_MAX_SHIFT + REM_STEPS - 1) / REM_STEPS;
  localparam int LAT_REM       = REM_STAGES + 3;

  localparam int NUM_COEF = 6;
  localparam logic [2:0] MAX_DROP = 3'd6;

  // configuration register indexes
  localparam logic [2:0] REG_TERMS = 3'd0;
  localparam logic [2:0] REG_COEF0 = 3'd1;
  localparam logic [2:0] REG_COEF1 = 3'd2;
  localparam logic [2:0] REG_COEF2 = 3'd3;
  localparam logic [2:0] REG_COEF3 = 3'd4;
  localparam logic [2:0] REG_COEF4 = 3'd5;
  localparam logic [2:0] REG_COEF5 = 3'd6;

  // leading zeros of a 48-bit word; 48 when zero
  function automatic logic [5:0] lead_zeros(input logic [47:0] v);
    logic [5:0] n;
    logic       hit;
    n   = 6'd48;
    hit = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 6'(47 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic is_nan(input logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

endpackage

>>> sv/spa_dly.sv
// Fixed-length delay line for pipeline side data.
module spa_dly #(
  parameter int W = 32,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sh_r [D];

  always_ff @(posedge clk) begin
    sh_r[0] <= d_i;
    for (int k = 1; k < D; k++) begin
      sh_r[k] <= sh_r[k-1];
    end
  end

  assign q_o = sh_r[D-1];

endmodule

>>> sv/spa_fadd.sv
// Three-stage binary32 adder, round to nearest even, subnormals kept.
module spa_fadd import spa_pkg::*; (
  input  logic        clk,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] s_o
);

  // stage 1: specials, swap, align
  logic        s1_spec_r, s1_sign_r, s1_sub_r;
  logic [31:0] s1_sword_r;
  logic [7:0]  s1_e_r;
  logic [26:0] s1_mb_r, s1_ms_r;

  logic        a_nan, b_nan, a_inf, b_inf, swap;
  logic [31:0] big, sml, sword;
  logic [7:0]  eb, es, d;
  logic [4:0]  sh;
  logic [50:0] full;

  always_comb begin
    a_nan = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'd0);
    b_nan = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'd0);
    a_inf = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    b_inf = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
    if (a_nan || b_nan || (a_inf && b_inf && (a_i[31] ^ b_i[31]))) begin
      sword = CANON_NAN;
    end else if (a_inf) begin
      sword = a_i;
    end else begin
      sword = b_i;
    end
    swap = b_i[30:0] > a_i[30:0];
    big  = swap ? b_i : a_i;
    sml  = swap ? a_i : b_i;
    eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d    = eb - es;
    sh   = (d > 8'd27) ? 5'd27 : d[4:0];
    full = {(sml[30:23] != 8'd0), sml[22:0], 27'd0} >> sh;
  end

  always_ff @(posedge clk) begin
    s1_spec_r  <= a_nan | b_nan | a_inf | b_inf;
    s1_sword_r <= sword;
    s1_sign_r  <= big[31];
    s1_sub_r   <= a_i[31] ^ b_i[31];
    s1_e_r     <= eb;
    s1_mb_r    <= {(big[30:23] != 8'd0), big[22:0], 3'd0};
    s1_ms_r    <= {full[50:25], full[24] | (|full[23:0])};
  end

  // stage 2: add and count leading zeros
  logic        s2_spec_r, s2_sign_r, s2_sub_r;
  logic [31:0] s2_sword_r;
  logic [7:0]  s2_e_r;
  logic [27:0] s2_sum_r;
  logic [4:0]  s2_lz_r;
  logic [27:0] sum;
  logic [5:0]  lz;

  always_comb begin
    sum = s1_sub_r ? ({1'b0, s1_mb_r} - {1'b0, s1_ms_r})
                   : ({1'b0, s1_mb_r} + {1'b0, s1_ms_r});
    lz  = lead_zeros({sum, 20'd0});
  end

  always_ff @(posedge clk) begin
    s2_spec_r  <= s1_spec_r;
    s2_sword_r <= s1_sword_r;
    s2_sign_r  <= s1_sign_r;
    s2_sub_r   <= s1_sub_r;
    s2_e_r     <= s1_e_r;
    s2_sum_r   <= sum;
    s2_lz_r    <= lz[4:0];
  end

  // stage 3: normalize, round, pack
  logic [26:0] n;
  logic [8:0]  ex, ef;
  logic [4:0]  lzm1, sl;
  logic [7:0]  lim;
  logic [31:0] pk;
  logic        inc;
  logic [31:0] res;

  always_comb begin
    lzm1 = s2_lz_r - 5'd1;
    lim  = s2_e_r - 8'd1;
    sl   = ({3'd0, lzm1} > lim) ? lim[4:0] : lzm1;
    if (s2_sum_r[27]) begin
      n  = {s2_sum_r[27:2], s2_sum_r[1] | s2_sum_r[0]};
      ex = {1'b0, s2_e_r} + 9'd1;
    end else begin
      n  = s2_sum_r[26:0] << sl;
      ex = {1'b0, s2_e_r} - {4'd0, sl};
    end
    ef  = n[26] ? ex : 9'd0;
    inc = n[2] & (n[1] | n[0] | n[3]);
    pk  = {ef, n[25:3]} + {31'd0, inc};
    if (s2_spec_r) begin
      res = s2_sword_r;
    end else if (s2_sum_r == 28'd0) begin
      res = {s2_sub_r ? 1'b0 : s2_sign_r, 31'd0};
    end else if (pk[31:23] >= 9'd255) begin
      res = {s2_sign_r, 8'hFF, 23'd0};
    end else begin
      res = {s2_sign_r, pk[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    s_o <= res;
  end

endmodule

>>> sv/spa_fmul.sv
// Three-stage binary32 multiplier, round to nearest even, subnormals kept.
module spa_fmul import spa_pkg::*; (
  input  logic        clk,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o
);

  // stage 1: specials and mantissa product
  logic        s1_spec_r, s1_sign_r;
  logic [31:0] s1_sword_r;
  logic [47:0] s1_prod_r;
  logic [9:0]  s1_e_r;

  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
  logic [31:0] sword;
  logic [7:0]  ea, eb;

  always_comb begin
    a_nan  = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'd0);
    b_nan  = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'd0);
    a_inf  = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    b_inf  = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
    a_zero = a_i[30:0] == 31'd0;
    b_zero = b_i[30:0] == 31'd0;
    sgn    = a_i[31] ^ b_i[31];
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      sword = CANON_NAN;
    end else if (a_inf || b_inf) begin
      sword = {sgn, 8'hFF, 23'd0};
    end else begin
      sword = {sgn, 31'd0};
    end
    ea = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
  end

  always_ff @(posedge clk) begin
    s1_spec_r  <= a_nan | b_nan | a_inf | b_inf | a_zero | b_zero;
    s1_sword_r <= sword;
    s1_sign_r  <= sgn;
    s1_prod_r  <= {(a_i[30:23] != 8'd0), a_i[22:0]} * {(b_i[30:23] != 8'd0), b_i[22:0]};
    s1_e_r     <= {2'd0, ea} + {2'd0, eb} - 10'd127;
  end

  // stage 2: find normalizing shift (left) or denormalizing shift (right)
  logic        s2_spec_r, s2_sign_r, s2_left_r, s2_ovf_r;
  logic [31:0] s2_sword_r;
  logic [47:0] s2_prod_r;
  logic [5:0]  s2_amt_r;
  logic [8:0]  s2_ex_r;

  logic [5:0]        lz, amt;
  logic signed [9:0] e_s, er, neg;
  logic              left, ovf;
  logic [8:0]        ex;

  always_comb begin
    lz  = lead_zeros(s1_prod_r);
    e_s = signed'(s1_e_r);
    er  = e_s + 10'sd1 - signed'({4'd0, lz});
    neg = -e_s;
    ovf = er >= 10'sd255;
    if (er > 10'sd0) begin
      left = 1'b1;
      amt  = lz;
      ex   = er[8:0];
    end else if (e_s >= 10'sd0) begin
      left = 1'b1;
      amt  = e_s[5:0];
      ex   = 9'd1;
    end else begin
      left = 1'b0;
      amt  = (neg > 10'sd50) ? 6'd50 : neg[5:0];
      ex   = 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    s2_spec_r  <= s1_spec_r;
    s2_sword_r <= s1_sword_r;
    s2_sign_r  <= s1_sign_r;
    s2_prod_r  <= s1_prod_r;
    s2_left_r  <= left;
    s2_amt_r   <= amt;
    s2_ex_r    <= ex;
    s2_ovf_r   <= ovf;
  end

  // stage 3: shift, round, pack
  logic [47:0] pn;
  logic [97:0] ext;
  logic        st, inc;
  logic [8:0]  ef;
  logic [31:0] pk, res;

  always_comb begin
    ext = {s2_prod_r, 50'd0} >> s2_amt_r;
    if (s2_left_r) begin
      pn = s2_prod_r << s2_amt_r;
      st = 1'b0;
    end else begin
      pn = ext[97:50];
      st = |ext[49:0];
    end
    inc = pn[23] & ((|pn[22:0]) | st | pn[24]);
    ef  = pn[47] ? s2_ex_r : 9'd0;
    pk  = {ef, pn[46:24]} + {31'd0, inc};
    if (s2_spec_r) begin
      res = s2_sword_r;
    end else if (s2_ovf_r || (pk[31:23] >= 9'd255)) begin
      res = {s2_sign_r, 8'hFF, 23'd0};
    end else begin
      res = {s2_sign_r, pk[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    p_o <= res;
  end

endmodule

>>> sv/spa_rem.sv
// Pipelined exact remainder of a binary32 word by the fixed period 2*PI_HI.
module spa_rem import spa_pkg::*; (
  input  logic        clk,
  input  logic [31:0] a_i,
  output logic [31:0] r_o,
  output logic        bad_o
);

  localparam logic [23:0] MD = {1'b1, PERIOD[22:0]};
  localparam logic [7:0]  ED = PERIOD[30:23];

  // side data per stage
  typedef struct packed {
    logic        sign;
    logic        bad;
    logic        below;
    logic [31:0] a;
    logic [7:0]  k;
  } rem_side_t;

  rem_side_t   side_r [REM_STAGES+1];
  logic [24:0] m_r    [REM_STAGES+1];

  function automatic logic [24:0] rem_run(input logic [24:0] m, input logic [7:0] k,
                                          input logic [7:0] base);
    logic [24:0] t;
    t = m;
    for (int j = 0; j < REM_STEPS; j++) begin
      if (base + 8'(j) < k) begin
        if (t >= {1'b0, MD}) t = t - {1'b0, MD};
        t = {t[23:0], 1'b0};
      end
    end
    return t;
  endfunction

  // entry stage and shift-subtract stages
  always_ff @(posedge clk) begin
    side_r[0].sign  <= a_i[31];
    side_r[0].bad   <= a_i[30:23] == 8'hFF;
    side_r[0].below <= a_i[30:0] < PERIOD[30:0];
    side_r[0].a     <= a_i;
    side_r[0].k     <= a_i[30:23] - ED;
    m_r[0]          <= {2'b01, a_i[22:0]};
    for (int g = 0; g < REM_STAGES; g++) begin
      side_r[g+1] <= side_r[g];
      m_r[g+1]    <= rem_run(m_r[g], side_r[g].k, 8'(g * REM_STEPS));
    end
  end

  // last subtract and leading zero count
  rem_side_t   f_side_r;
  logic [23:0] f_m_r;
  logic [4:0]  f_lz_r;
  logic [24:0] mf;
  logic [5:0]  lz;

  always_comb begin
    mf = (m_r[REM_STAGES] >= {1'b0, MD}) ? (m_r[REM_STAGES] - {1'b0, MD}) : m_r[REM_STAGES];
    lz = lead_zeros({mf[23:0], 24'd0});
  end

  always_ff @(posedge clk) begin
    f_side_r <= side_r[REM_STAGES];
    f_m_r    <= mf[23:0];
    f_lz_r   <= lz[4:0];
  end

  // normalize and pack
  logic [23:0] mn;
  logic [31:0] res;

  always_comb begin
    mn = f_m_r << f_lz_r;
    if (f_side_r.bad) begin
      res = CANON_NAN;
    end else if (f_side_r.below) begin
      res = f_side_r.a;
    end else if (f_m_r == 24'd0) begin
      res = {f_side_r.sign, 31'd0};
    end else begin
      res = {f_side_r.sign, ED - {3'd0, f_lz_r}, mn[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    r_o   <= res;
    bad_o <= f_side_r.bad;
  end

endmodule

>>> sv/sine_poly_approx_f32.sv
// Top level of the pipelined single-precision polynomial sine.
//
// Usage:
//   Input: drive in_angle_bits (binary32 radians) and pulse start. An item is
//   taken on every rising edge where start is high and busy is low; busy stays
//   low, so one angle can enter every cycle.
//   Output: out_valid is high for exactly one cycle with out_sine_bits holding
//   the binary32 sine. Results leave in the order angles went in. There is no
//   backpressure: the receiver must take each result in its cycle.
//   Throughput: one item per cycle. Depth is set by the 16-stage exact
//   remainder shifter and the Horner chain of eleven float operations.
//   Config: cfg_valid/cfg_ready write cfg_wdata to register cfg_index
//   (0 terms_dropped, 1..6 coef_0..coef_5); cfg_ready is always high. Writes
//   must happen only while the pipeline is empty.
//   Reset: rst_n low zeroes config and valid registers, dropping items in flight.
//   NaN results always come out as 0x7FC00000.
module sine_poly_approx_f32 import spa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_angle_bits,
  output logic        out_valid,
  output logic [31:0] out_sine_bits,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  // pipeline timeline, relative to the input register
  localparam int T_SH  = LAT_ADD;                     // angle + pi
  localparam int T_REM = T_SH + LAT_REM;              // reduced angle
  localparam int T_X   = T_REM + LAT_ADD;             // x
  localparam int T_S   = T_X + LAT_MUL;               // s = x*x
  localparam int T_A2  = T_X + 2 * LAT_ADD;           // (x -/+ pi_hi) -/+ pi_lo
  localparam int T_R1  = T_A2 + LAT_MUL;
  localparam int T_R2  = T_R1 + LAT_MUL;
  localparam int T_P   = T_S + NUM_COEF * LAT_ADD + (NUM_COEF - 1) * LAT_MUL;
  localparam int T_R3  = T_P + LAT_MUL;
  localparam int T_OUT = T_R3 + 1;

  // config registers
  logic [2:0]  terms_r;
  logic [31:0] coef_r [NUM_COEF];

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      terms_r <= 3'd0;
      for (int i = 0; i < NUM_COEF; i++) coef_r[i] <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TERMS: terms_r   <= cfg_wdata[2:0];
        REG_COEF0: coef_r[0] <= cfg_wdata;
        REG_COEF1: coef_r[1] <= cfg_wdata;
        REG_COEF2: coef_r[2] <= cfg_wdata;
        REG_COEF3: coef_r[3] <= cfg_wdata;
        REG_COEF4: coef_r[4] <= cfg_wdata;
        REG_COEF5: coef_r[5] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // valid bits travel alongside the datapath
  logic [T_OUT:0] vld_r;
  logic [31:0]    angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[T_OUT-1:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    angle_r <= in_angle_bits;
  end

  // range reduction: x = fmod(angle + pi, 2pi) - pi
  logic [31:0] shifted, rem_bits, x;
  logic        rem_bad;

  spa_fadd u_shift (.clk(clk), .a_i(angle_r), .b_i(PI_HI), .s_o(shifted));
  spa_rem  u_rem   (.clk(clk), .a_i(shifted), .r_o(rem_bits), .bad_o(rem_bad));
  spa_fadd u_xsub  (.clk(clk), .a_i(rem_bits), .b_i(NEG_PI_HI), .s_o(x));

  // s = x*x
  logic [31:0] s;
  spa_fmul u_sq (.clk(clk), .a_i(x), .b_i(x), .p_o(s));

  // root factors: x*((x-pi_hi)-pi_lo)*((x+pi_hi)+pi_lo)
  logic [31:0] a1, b1, a2, b2, x_d, b2_d, r1, r2, r2_d;

  spa_fadd u_a1 (.clk(clk), .a_i(x),  .b_i(NEG_PI_HI), .s_o(a1));
  spa_fadd u_b1 (.clk(clk), .a_i(x),  .b_i(PI_HI),     .s_o(b1));
  spa_fadd u_a2 (.clk(clk), .a_i(a1), .b_i(NEG_PI_LO), .s_o(a2));
  spa_fadd u_b2 (.clk(clk), .a_i(b1), .b_i(PI_LO),     .s_o(b2));

  spa_dly #(.W(WORD_W), .D(T_A2 - T_X)) u_xdly  (.clk(clk), .d_i(x),  .q_o(x_d));
  spa_dly #(.W(WORD_W), .D(T_R1 - T_A2)) u_bdly (.clk(clk), .d_i(b2), .q_o(b2_d));

  spa_fmul u_r1 (.clk(clk), .a_i(x_d), .b_i(a2),   .p_o(r1));
  spa_fmul u_r2 (.clk(clk), .a_i(r1),  .b_i(b2_d), .p_o(r2));

  spa_dly #(.W(WORD_W), .D(T_P - T_R2)) u_rdly (.clk(clk), .d_i(r2), .q_o(r2_d));

  // Horner chain. A skipped term adds -0 to the starting +0, which keeps p = +0.
  logic [2:0]  drop;
  logic [31:0] hp [NUM_COEF+1];
  logic [31:0] hq [NUM_COEF];
  logic [31:0] cf [NUM_COEF];

  assign drop  = (terms_r > MAX_DROP) ? MAX_DROP : terms_r;
  assign hp[0] = POS_ZERO;

  for (genvar i = 0; i < NUM_COEF; i++) begin : g_horner
    assign cf[i] = (3'(i) >= drop) ? coef_r[NUM_COEF-1-i] : NEG_ZERO;
    spa_fadd u_add (.clk(clk), .a_i(hp[i]), .b_i(cf[i]), .s_o(hq[i]));
    if (i < NUM_COEF - 1) begin : g_mul
      logic [31:0] s_d;
      spa_dly #(.W(WORD_W), .D((i + 1) * LAT_ADD + i * LAT_MUL)) u_sdly (
        .clk(clk), .d_i(s), .q_o(s_d)
      );
      spa_fmul u_mul (.clk(clk), .a_i(hq[i]), .b_i(s_d), .p_o(hp[i+1]));
    end else begin : g_last
      assign hp[i+1] = hq[i];
    end
  end

  // final product and NaN canonicalization
  logic [31:0] r3;
  logic        bad_d;

  spa_fmul u_r3 (.clk(clk), .a_i(r2_d), .b_i(hp[NUM_COEF]), .p_o(r3));
  spa_dly #(.W(1), .D(T_R3 - T_REM)) u_baddly (.clk(clk), .d_i(rem_bad), .q_o(bad_d));

  logic [31:0] out_sine_r;

  always_ff @(posedge clk) begin
    out_sine_r <= (bad_d || is_nan(r3)) ? CANON_NAN : r3;
  end

  assign out_sine_bits = out_sine_r;
  assign out_valid     = vld_r[T_OUT];

  // checks
  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, T_OUT + 1))
    else $error("result strobe without a matching accepted item");

  a_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!is_nan(out_sine_bits) || (out_sine_bits == CANON_NAN)))
    else $error("non-canonical NaN on output");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[T_REM] && !rem_bad) |-> (rem_bits[30:0] < PERIOD[30:0]))
    else $error("reduced angle not below the period");

endmodule
